// ===== rtl/core/pipt_pkg.sv =====
`timescale 1ns / 1ps

package pipt_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    ACT_FRAME  = 2'd0,
    ACT_LUMA   = 2'd1,
    ACT_CHROMA = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TRANS_FRAMES = 3'd2;
  localparam logic [2:0] REG_START_LEFT   = 3'd3;
  localparam logic [2:0] REG_START_TOP    = 3'd4;
  localparam logic [2:0] REG_INVERSE      = 3'd5;

  localparam int DIM_W    = 13;           // frame and window dimensions
  localparam int POS_W    = 12;           // window corner
  localparam int FRAME_W  = 16;           // frame index and duration
  localparam int SUM_W    = DIM_W + 1;    // corner plus size
  localparam int PROD_W   = DIM_W + FRAME_W;
  localparam int QUO_W    = DIM_W;        // every quotient is at most a dimension
  localparam int STEP_W   = $clog2(QUO_W);
  localparam int SAMPLE_W = 8;

  // window quantity being computed
  localparam logic [1:0] JOB_WIDTH  = 2'd0;
  localparam logic [1:0] JOB_HEIGHT = 2'd1;
  localparam logic [1:0] JOB_LEFT   = 2'd2;
  localparam logic [1:0] JOB_TOP    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic       busy;
    logic       mul;
    logic       load;
    logic       step;
    logic       write;
    logic [1:0] job;
  } cmd_t;

  typedef struct packed {
    logic frame_start;
  } status_t;

endpackage

// ===== rtl/core/pipt_ctrl.sv =====
`timescale 1ns / 1ps

module pipt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  pipt_pkg::status_t status,
  output pipt_pkg::cmd_t    cmd
);
  import pipt_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [1:0]        job_r, job_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.job   = job_r;
    unique case (state_r)
      ST_IDLE: begin
        if (status.frame_start) begin
          state_nxt = ST_MUL;
          job_nxt   = JOB_WIDTH;
        end
      end
      ST_MUL: begin
        cmd.busy  = 1'b1;
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.busy  = 1'b1;
        cmd.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.busy = 1'b1;
        cmd.step = 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = ST_WRITE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.busy  = 1'b1;
        cmd.write = 1'b1;
        if (job_r == JOB_TOP) begin
          state_nxt = ST_IDLE;
        end else begin
          job_nxt   = job_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pipt_datapath.sv =====
`timescale 1ns / 1ps

module pipt_datapath #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [2:0]                       cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [pipt_pkg::SAMPLE_W-1:0]    in_first_y_or_cb,
  input  logic [pipt_pkg::SAMPLE_W-1:0]    in_second_y_or_cb,
  input  logic [pipt_pkg::SAMPLE_W-1:0]    in_first_cr,
  input  logic [pipt_pkg::SAMPLE_W-1:0]    in_second_cr,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pipt_pkg::SAMPLE_W-1:0]    out_y_or_cb,
  output logic [pipt_pkg::SAMPLE_W-1:0]    out_cr,
  output logic                             out_inside_window,
  output logic [pipt_pkg::FRAME_W-1:0]     out_current_frame,
  input  pipt_pkg::cmd_t                   cmd,
  output pipt_pkg::status_t                status
);
  import pipt_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam logic [SUM_W-1:0] MAX_DIM = SUM_W'(MAX_DIMENSION);

  // configuration
  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [FRAME_W-1:0] trans_frames_r;
  logic [POS_W-1:0]   start_left_r, start_top_r;
  logic               inverse_r;

  // per-frame state
  logic [FRAME_W-1:0] frame_index_r;
  logic [FRAME_W-1:0] grow_r, move_r;
  logic [DIM_W-1:0]   win_width_r, win_height_r;
  logic [POS_W-1:0]   win_left_r, win_top_r;
  logic [CNT_W-1:0]   col_r, row_r;
  logic               chroma_r;

  // divider
  logic [PROD_W-1:0]  product_r;
  logic [FRAME_W-1:0] rem_r;
  logic [QUO_W-1:0]   quo_r;

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_y_r, out_cr_r;
  logic                out_inside_r;

  logic [DIM_W-1:0]   dim_w, dim_h, op;
  logic [FRAME_W-1:0] div_d, f_inc, f_new, d_minus_f, fac;
  logic [FRAME_W:0]   trial;
  logic               trial_ge;
  logic [DIM_W-1:0]   w_e, h_e, ww_e, wh_e;
  logic [POS_W-1:0]   wl_e, wt_e;
  logic [SUM_W-1:0]   col_ext, row_ext;
  logic               in_win, col_last, row_last, sel_second;
  logic               frame_fire, sample_fire, plane_match;

  always_comb begin
    dim_w = (SUM_W'(frame_width_r) > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : frame_width_r;
    dim_h = (SUM_W'(frame_height_r) > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : frame_height_r;
    div_d = (trans_frames_r == '0) ? FRAME_W'(1) : trans_frames_r;
    f_inc = frame_index_r + 1'b1;
    f_new = (f_inc >= div_d) ? '0 : f_inc;
    d_minus_f = div_d - f_new;
  end

  // multiplier operand selection
  always_comb begin
    unique case (cmd.job)
      JOB_WIDTH:  op = dim_w;
      JOB_HEIGHT: op = dim_h;
      JOB_LEFT:   op = DIM_W'(start_left_r);
      JOB_TOP:    op = DIM_W'(start_top_r);
      default:    op = dim_w;
    endcase
    fac = (cmd.job == JOB_WIDTH || cmd.job == JOB_HEIGHT) ? grow_r : move_r;
  end

  // one quotient bit per step, restoring
  always_comb begin
    trial    = {rem_r, quo_r[QUO_W-1]};
    trial_ge = trial >= {1'b0, div_d};
  end

  // plane geometry, halved for chroma
  always_comb begin
    w_e  = chroma_r ? (dim_w >> 1) : dim_w;
    h_e  = chroma_r ? (dim_h >> 1) : dim_h;
    ww_e = chroma_r ? (win_width_r >> 1) : win_width_r;
    wh_e = chroma_r ? (win_height_r >> 1) : win_height_r;
    wl_e = chroma_r ? (win_left_r >> 1) : win_left_r;
    wt_e = chroma_r ? (win_top_r >> 1) : win_top_r;
    col_ext = SUM_W'(col_r);
    row_ext = SUM_W'(row_r);
    in_win = (col_ext >= SUM_W'(wl_e)) && (col_ext < SUM_W'(wl_e) + SUM_W'(ww_e)) &&
             (row_ext >= SUM_W'(wt_e)) && (row_ext < SUM_W'(wt_e) + SUM_W'(wh_e));
    col_last = (col_ext + 1'b1) >= SUM_W'(w_e);
    row_last = (row_ext + 1'b1) >= SUM_W'(h_e);
    sel_second = in_win ^ inverse_r;
  end

  always_comb begin
    in_stall    = cmd.busy || (out_valid_r && out_stall);
    plane_match = (in_action == ACT_LUMA && !chroma_r) || (in_action == ACT_CHROMA && chroma_r);
    frame_fire  = in_valid && !in_stall && (in_action == ACT_FRAME);
    sample_fire = in_valid && !in_stall && plane_match;
    status.frame_start = frame_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(720);
      frame_height_r <= DIM_W'(576);
      trans_frames_r <= FRAME_W'(25);
      start_left_r   <= '0;
      start_top_r    <= '0;
      inverse_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        REG_TRANS_FRAMES: trans_frames_r <= cfg_data;
        REG_START_LEFT:   start_left_r   <= cfg_data[POS_W-1:0];
        REG_START_TOP:    start_top_r    <= cfg_data[POS_W-1:0];
        REG_INVERSE:      inverse_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_index_r <= '1;
      win_width_r   <= '0;
      win_height_r  <= '0;
      win_left_r    <= '0;
      win_top_r     <= '0;
      col_r         <= '0;
      row_r         <= '0;
      chroma_r      <= 1'b0;
    end else begin
      if (frame_fire) begin
        frame_index_r <= f_new;
        col_r         <= '0;
        row_r         <= '0;
        chroma_r      <= 1'b0;
      end else if (sample_fire) begin
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r    <= '0;
            chroma_r <= ~chroma_r;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (cmd.write) begin
        unique case (cmd.job)
          JOB_WIDTH:  win_width_r  <= quo_r;
          JOB_HEIGHT: win_height_r <= quo_r;
          JOB_LEFT:   win_left_r   <= quo_r[POS_W-1:0];
          JOB_TOP:    win_top_r    <= quo_r[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      grow_r <= inverse_r ? d_minus_f : f_new;
      move_r <= inverse_r ? f_new : d_minus_f;
    end
    if (cmd.mul) begin
      product_r <= PROD_W'(op) * PROD_W'(fac);
    end
    // the quotient fits in QUO_W bits, so the upper part is already below the divisor
    if (cmd.load) begin
      rem_r <= product_r[PROD_W-1:QUO_W];
      quo_r <= product_r[QUO_W-1:0];
    end else if (cmd.step) begin
      rem_r <= trial_ge ? FRAME_W'(trial - {1'b0, div_d}) : trial[FRAME_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sample_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      out_y_r      <= sel_second ? in_second_y_or_cb : in_first_y_or_cb;
      out_cr_r     <= chroma_r ? (sel_second ? in_second_cr : in_first_cr) : '0;
      out_inside_r <= in_win;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_y_or_cb       = out_y_r;
  assign out_cr            = out_cr_r;
  assign out_inside_window = out_inside_r;
  assign out_current_frame = frame_index_r;

endmodule

// ===== rtl/core/picture_in_picture_transition_core.sv =====
`timescale 1ns / 1ps

// picture-in-picture transition for two 4:2:0 streams. a frame-start beat
// advances the frame index and recomputes the window; luma beats then
// chroma Cb/Cr beats follow in raster order, one result beat each. sample
// beats are taken one per cycle whenever no window is being computed and the
// output register is free or draining. a frame-start beat holds off the input
// while one multiplier and a bit-serial divider (13 quotient bits) work out
// window width, height, left and top in turn. luma beats in the chroma plane,
// chroma beats in the luma plane and action 3 are consumed with no result.
// config writes are always ready and should only be issued while the block
// is idle.
module picture_in_picture_transition_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_first_y_or_cb,
  input  logic [7:0]  in_second_y_or_cb,
  input  logic [7:0]  in_first_cr,
  input  logic [7:0]  in_second_cr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_y_or_cb,
  output logic [7:0]  out_cr,
  output logic        out_inside_window,
  output logic [15:0] out_current_frame
);
  import pipt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pipt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  pipt_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_first_y_or_cb  (in_first_y_or_cb),
    .in_second_y_or_cb (in_second_y_or_cb),
    .in_first_cr       (in_first_cr),
    .in_second_cr      (in_second_cr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_y_or_cb       (out_y_or_cb),
    .out_cr            (out_cr),
    .out_inside_window (out_inside_window),
    .out_current_frame (out_current_frame),
    .cmd               (cmd),
    .status            (status)
  );

`ifndef SYNTHESIS
  // a frame start must hand over to the divider sequence
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_FRAME) |=> (cmd.busy && in_stall))
    else $error("frame start did not start window computation");

  // a new result only follows an accepted sample beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) ##1 out_valid |->
      $past(in_valid && !in_stall && (in_action == ACT_LUMA || in_action == ACT_CHROMA)))
    else $error("result without an accepted sample");

  // no sample is taken while the window is being computed
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.busy |-> in_stall)
    else $error("input accepted during window computation");
`endif

endmodule

// ===== dv/picture_in_picture_transition_core_tb.sv =====
`timescale 1ns / 1ps

module picture_in_picture_transition_core_tb;
  import pipt_pkg::*;

  localparam int unsigned MAX_DIM = 4096;
  localparam logic [2:0] REG_SPARE = 3'd6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int TARGET_BEATS = 1900;
  localparam int CALM_BEATS = 200;
  localparam int LONG_HOLD = 250;
  localparam int unsigned FULL_FRAME = 32'h7fff_ffff;

  typedef struct packed {
    action_t    act;
    logic [7:0] first_y_cb;
    logic [7:0] second_y_cb;
    logic [7:0] first_cr;
    logic [7:0] second_cr;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0]  y_cb;
    logic [7:0]  cr;
    logic        in_window;
    logic [15:0] frame;
  } pix_result_t;

  class composite_scoreboard;
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [15:0] duration;
    logic [11:0] start_l;
    logic [11:0] start_t;
    logic        inverse;
    logic [15:0] frame_idx;
    int unsigned col, row, win_w, win_h, win_l, win_t;
    logic        chroma_plane;
    pix_result_t pending_pixels[$];
    int          errors;

    function new();
      frame_w = 720;
      frame_h = 576;
      duration = 25;
      start_l = 0;
      start_t = 0;
      inverse = 0;
      frame_idx = 16'hffff;
      col = 0;
      row = 0;
      win_w = 0;
      win_h = 0;
      win_l = 0;
      win_t = 0;
      chroma_plane = 0;
      errors = 0;
    endfunction

    function int unsigned clamp(logic [12:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_FRAME_WIDTH:  frame_w = v[12:0];
        REG_FRAME_HEIGHT: frame_h = v[12:0];
        REG_TRANS_FRAMES: duration = v;
        REG_START_LEFT:   start_l = v[11:0];
        REG_START_TOP:    start_t = v[11:0];
        REG_INVERSE:      inverse = v[0];
        default: ;
      endcase
    endfunction

    // window size and corner for the next frame of the transition
    function void advance_frame();
      int unsigned d, f, grow, move;
      d = (duration != 0) ? duration : 1;
      f = (int'(frame_idx) + 1) & 32'hffff;
      if (f >= d) f = 0;
      frame_idx = f[15:0];
      if (inverse) begin
        grow = d - f;
        move = f;
      end else begin
        grow = f;
        move = d - f;
      end
      win_w = clamp(frame_w) * grow / d;
      win_h = clamp(frame_h) * grow / d;
      win_l = int'(start_l) * move / d;
      win_t = int'(start_t) * move / d;
      col = 0;
      row = 0;
      chroma_plane = 0;
    endfunction

    function bit take_beat(pix_beat_t b);
      int unsigned w, h, ww, wh, wl, wt;
      bit chroma, in_win;
      pix_result_t r;
      if (b.act == ACT_FRAME) begin
        advance_frame();
        return 0;
      end
      if (b.act == ACT_NONE) return 0;
      chroma = (b.act == ACT_CHROMA);
      if (chroma != chroma_plane) return 0;
      w = clamp(frame_w);
      h = clamp(frame_h);
      ww = win_w;
      wh = win_h;
      wl = win_l;
      wt = win_t;
      if (chroma) begin
        w = w >> 1;
        h = h >> 1;
        ww = ww >> 1;
        wh = wh >> 1;
        wl = wl >> 1;
        wt = wt >> 1;
      end
      in_win = col >= wl && col < wl + ww && row >= wt && row < wt + wh;
      // second stream is the windowed one unless inverse
      if (in_win != inverse) begin
        r.y_cb = b.second_y_cb;
        r.cr = b.second_cr;
      end else begin
        r.y_cb = b.first_y_cb;
        r.cr = b.first_cr;
      end
      if (!chroma) r.cr = '0;
      r.in_window = in_win;
      r.frame = frame_idx;
      pending_pixels.push_back(r);
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          row = 0;
          chroma_plane = ~chroma_plane;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      return 1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [7:0] y_cb, logic [7:0] cr, logic in_window,
                               logic [15:0] frame);
      pix_result_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual y_cb %0d cr %0d win %0d frame %0d",
                 $time, y_cb, cr, in_window, frame);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      check_field("y_cb", want.y_cb, y_cb);
      check_field("cr", want.cr, cr);
      check_field("in_window", want.in_window, in_window);
      check_field("current_frame", want.frame, frame);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_NONE;
  logic [7:0]  in_first_y_or_cb = '0;
  logic [7:0]  in_second_y_or_cb = '0;
  logic [7:0]  in_first_cr = '0;
  logic [7:0]  in_second_cr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_y_or_cb;
  logic [7:0]  out_cr;
  logic        out_inside_window;
  logic [15:0] out_current_frame;

  composite_scoreboard sb;
  bit calm = 0;
  bit hold_req = 0;
  bit rx_quiet = 0;
  int rx_segment = 0;
  int gap_odds = 0;
  int idle_cycles = 0;
  int beats_sent = 0;
  int n_samples = 0;
  int n_frames = 0;
  int n_ignored = 0;
  int phase = 0;
  int unsigned fw, fh, dur, sl, st, junk, frames, limit;
  bit inv;

  picture_in_picture_transition_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_first_y_or_cb  (in_first_y_or_cb),
    .in_second_y_or_cb (in_second_y_or_cb),
    .in_first_cr       (in_first_cr),
    .in_second_cr      (in_second_cr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_y_or_cb       (out_y_or_cb),
    .out_cr            (out_cr),
    .out_inside_window (out_inside_window),
    .out_current_frame (out_current_frame)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_result(out_y_or_cb, out_cr, out_inside_window, out_current_frame);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("picture_in_picture_transition_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall bursts in some stretches, none in others, one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (rx_segment == 0) begin
        rx_quiet = ($urandom_range(0, 2) == 0);
        rx_segment = $urandom_range(30, 300);
      end
      rx_segment--;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(action_t act, logic [7:0] a0, logic [7:0] b0,
                           logic [7:0] a1, logic [7:0] b1);
    pix_beat_t b;
    if (beats_sent >= TARGET_BEATS - CALM_BEATS) calm = 1;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_first_y_or_cb <= a0;
    in_second_y_or_cb <= b0;
    in_first_cr <= a1;
    in_second_cr <= b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    b.act = act;
    b.first_y_cb = a0;
    b.second_y_cb = b0;
    b.first_cr = a1;
    b.second_cr = b1;
    if (sb.take_beat(b)) n_samples++;
    else if (act == ACT_FRAME) n_frames++;
    else n_ignored++;
    beats_sent++;
  endtask

  task automatic send_random(action_t act);
    send_beat(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // frame start, then the luma plane and the Cb/Cr plane with some stray beats
  task automatic send_frame(int unsigned cap);
    int unsigned w, h, luma_n, chroma_n, sent;
    action_t kind, stray;
    sent = 0;
    send_random(ACT_FRAME);
    w = sb.clamp(sb.frame_w);
    h = sb.clamp(sb.frame_h);
    luma_n = (w != 0 ? w : 1) * (h != 0 ? h : 1);
    chroma_n = ((w >> 1) != 0 ? (w >> 1) : 1) * ((h >> 1) != 0 ? (h >> 1) : 1);
    if (cap == 0)
      cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, luma_n + chroma_n)
                                        : luma_n + chroma_n;
    for (int p = 0; p < 2; p++) begin
      kind = p ? ACT_CHROMA : ACT_LUMA;
      stray = p ? ACT_LUMA : ACT_CHROMA;
      for (int unsigned i = 0; i < (p ? chroma_n : luma_n); i++) begin
        if (sent >= cap || beats_sent >= TARGET_BEATS) return;
        if ($urandom_range(0, 24) == 0) send_random($urandom_range(0, 1) ? stray : ACT_NONE);
        send_random(kind);
        sent++;
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // wait out every pending result plus any window computation still running
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // no frame start yet: empty window, frame index all ones
    send_beat(ACT_LUMA, 8'h00, 8'hff, 8'hff, 8'h00);
    send_beat(ACT_LUMA, 8'hff, 8'h00, 8'h00, 8'hff);
    send_random(ACT_NONE);
    send_random(ACT_CHROMA);
    send_random(ACT_FRAME);
    send_beat(ACT_LUMA, 8'h55, 8'haa, 8'h5a, 8'ha5);
    send_beat(ACT_LUMA, 8'haa, 8'h55, 8'ha5, 8'h5a);
    settle();

    // zero duration counts as one frame; inverse gives a full first-stream window
    write_reg(REG_FRAME_WIDTH, 16'd4);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    write_reg(REG_TRANS_FRAMES, 16'd0);
    write_reg(REG_START_LEFT, 16'd1);
    write_reg(REG_START_TOP, 16'd0);
    write_reg(REG_INVERSE, 16'd1);
    write_reg(REG_SPARE, 16'hffff);
    cfg_valid <= 1'b0;
    send_frame(FULL_FRAME);
    settle();

    // mode flips stream choice at once, geometry waits for the next frame start
    write_reg(REG_INVERSE, 16'd0);
    cfg_valid <= 1'b0;
    send_random(ACT_LUMA);
    send_random(ACT_LUMA);

    while (beats_sent < TARGET_BEATS) begin
      settle();
      fw = ($urandom_range(0, 4) != 0) ? 2 * $urandom_range(1, 8) : $urandom_range(0, 24);
      fh = ($urandom_range(0, 4) != 0) ? 2 * $urandom_range(1, 8) : $urandom_range(0, 24);
      case ($urandom_range(0, 5))
        0:       dur = $urandom_range(0, 1);
        1:       dur = 65535;
        2, 3:    dur = $urandom_range(2, 6);
        default: dur = $urandom_range(2, 40);
      endcase
      sl = ($urandom_range(0, 3) != 0) ? $urandom_range(0, fw + 2) : $urandom_range(0, 4095);
      st = ($urandom_range(0, 3) != 0) ? $urandom_range(0, fh + 2) : $urandom_range(0, 4095);
      inv = $urandom_range(0, 1);
      frames = $urandom_range(1, 6);
      limit = 0;
      case (phase)
        0: begin
          // oversized width is clamped; widest corner, longest transition
          fw = 13'h1fff;
          fh = 2;
          dur = 65535;
          sl = 4095;
          st = 4095;
          inv = 1;
          frames = 2;
          limit = 48;
        end
        1: begin
          fw = 4096;
          fh = 4096;
          dur = 1;
          sl = 0;
          st = 4095;
          inv = 0;
          frames = 2;
          limit = 40;
        end
        2: begin
          fw = 16;
          fh = 16;
          dur = 3;
          sl = 5;
          st = 3;
          frames = 2;
          limit = FULL_FRAME;
          hold_req = 1;
        end
        default: ;
      endcase
      junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (phase < 4 || $urandom_range(0, 2) != 0)
        write_reg(REG_FRAME_WIDTH, 16'(fw) | 16'(junk << 13));
      if (phase < 4 || $urandom_range(0, 2) != 0) write_reg(REG_FRAME_HEIGHT, 16'(fh));
      if (phase < 4 || $urandom_range(0, 2) != 0) write_reg(REG_TRANS_FRAMES, 16'(dur));
      if (phase < 4 || $urandom_range(0, 2) != 0) write_reg(REG_START_LEFT, 16'(sl));
      if (phase < 4 || $urandom_range(0, 2) != 0) write_reg(REG_START_TOP, 16'(st));
      if (phase < 4 || $urandom_range(0, 2) != 0) write_reg(REG_INVERSE, 16'(inv));
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE + 3'($urandom_range(0, 1)),
                                               16'($urandom));
      cfg_valid <= 1'b0;
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 20);
      if (beats_sent >= TARGET_BEATS - CALM_BEATS) calm = 1;
      repeat (frames) send_frame(limit);
      phase++;
    end

    calm = 1;
    settle();
    sb.errors += sb.pending_pixels.size();
    $display("%0d beats: %0d samples checked, %0d frame starts, %0d ignored, %0d settings",
             beats_sent, n_samples, n_frames, n_ignored, phase + 2);
    $display("normal and inverse windows, clamped and degenerate frames, output hold, drains");
    if (sb.errors == 0) begin
      $display("picture_in_picture_transition_core verification clean");
    end else begin
      $display("picture_in_picture_transition_core verification failed");
    end
    $finish;
  end

endmodule
